FILE: src/kmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd_pkg
// Shared types, constants and helper functions of the key manager dispatcher.
// ----------------------------------------------------------------------------
package kmd_pkg;

   localparam int MAX_MANAGERS_DEF = 8;
   localparam int DATA_W = 32;
   localparam int CNT_W = 4;
   localparam int SUM_W = 13;
   localparam int ITER_W = 4;
   localparam int ADDR_W = 4;

   localparam logic [ITER_W-1:0] FP_ITERS = 4'd4;
   localparam logic [ITER_W-1:0] RR_ITERS = 4'd8;

   localparam logic [1:0] MODE_FP = 2'd0;
   localparam logic [1:0] MODE_RR = 2'd1;
   localparam logic [1:0] MODE_TUNE = 2'd2;

   localparam logic [1:0] REG_MODE = 2'd0;
   localparam logic [1:0] REG_COUNT = 2'd1;
   localparam logic [1:0] REG_THRESH = 2'd2;

   typedef struct packed {
      logic [63:0] fp_word0;
      logic [63:0] fp_word1;
      logic [63:0] fp_word2;
      logic [63:0] fp_word3;
   } req_data_type;

   typedef struct packed {
      logic [2:0] manager_index;
      logic       rebalanced;
   } rsp_data_type;

   typedef struct packed {
      logic                start;
      logic [DATA_W-1:0]   dividend;
      logic [CNT_W-1:0]    divisor;
      logic [ITER_W-1:0]   iters;
   } rem_req_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] remainder;
   } rem_sts_type;

   function automatic logic [10:0] word_byte_sum(input logic [63:0] word);
      logic [10:0] acc;
      acc = '0;
      for (int b = 0; b < 8; b++) begin
         acc = acc + 11'(word[8*b +: 8]);
      end
      return acc;
   endfunction

   function automatic logic [CNT_W-1:0] rem_step(input logic [CNT_W-1:0] r,
                                                 input logic bit_in,
                                                 input logic [CNT_W-1:0] d);
      logic [CNT_W:0] t;
      t = {r, bit_in};
      if (t >= {1'b0, d}) begin
         return CNT_W'(t - {1'b0, d});
      end
      return CNT_W'(t);
   endfunction

endpackage

FILE: src/kmd_rem_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd_rem_unit
// Iterative remainder unit, four restoring steps per cycle on a small divisor.
// ----------------------------------------------------------------------------
module kmd_rem_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  kmd_pkg::rem_req_type rem_req,
   output kmd_pkg::rem_sts_type rem_sts
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [kmd_pkg::ITER_W-1:0]   iter_ff, iter_in;
   logic [kmd_pkg::CNT_W-1:0]    rem_ff, rem_in;
   logic [kmd_pkg::CNT_W-1:0]    div_ff, div_in;
   logic [kmd_pkg::DATA_W-1:0]   shift_ff, shift_in;
   logic [kmd_pkg::CNT_W-1:0]    step_rem;

   always_comb begin
      step_rem = rem_ff;
      for (int k = 0; k < 4; k++) begin
         step_rem = kmd_pkg::rem_step(step_rem, shift_ff[kmd_pkg::DATA_W-1-k], div_ff);
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      shift_in = shift_ff;
      if (rem_req.start) begin
         busy_in = 1'b1;
         iter_in = rem_req.iters;
         rem_in = '0;
         div_in = rem_req.divisor;
         shift_in = rem_req.dividend;
      end else if (busy_ff) begin
         rem_in = step_rem;
         shift_in = {shift_ff[kmd_pkg::DATA_W-5:0], 4'b0000};
         iter_in = iter_ff - 4'd1;
         if (iter_ff == 4'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      shift_ff <= shift_in;
   end

   assign rem_sts.done = done_ff;
   assign rem_sts.remainder = rem_ff;

endmodule

FILE: src/kmd_load_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd_load_mem
// Load counter memory with one read and one write port and per-entry valid
// bits, so that entries never written read as zero after reset.
// ----------------------------------------------------------------------------
module kmd_load_mem #(
   parameter int DEPTH = kmd_pkg::MAX_MANAGERS_DEF,
   parameter int IDX_W = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [IDX_W-1:0]           rd_addr,
   output logic [kmd_pkg::DATA_W-1:0] rd_data,
   input  logic                       wr_en,
   input  logic [IDX_W-1:0]           wr_addr,
   input  logic [kmd_pkg::DATA_W-1:0] wr_data
);

   logic [kmd_pkg::DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]           valid_ff;
   logic [kmd_pkg::DATA_W-1:0] rd_q_ff;
   logic                       rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

FILE: src/key_manager_dispatch_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_manager_dispatch_top
// Picks a key manager for each 32-byte chunk fingerprint and counts the
// assignments per manager.
// ----------------------------------------------------------------------------
// The request channel carries one fingerprint per transfer; the response
// channel returns the chosen manager index and the rebalanced flag, one
// response transfer per request transfer, in order.
// The user must write registers over the APB port only while the block is
// idle; the block does not enforce this. A fingerprint is summed one 64-bit
// word per cycle, and the remainder modulo the manager count comes from a
// shared iterative unit that retires four dividend bits per cycle. In tunable
// mode the counters are then scanned one per cycle through the counter
// memory's read port.
// The block takes one item at a time; req_ready is high only while idle.
// The result sits in an output register, so a new request is taken while the
// previous response waits; a stalled receiver holds the next item back only
// when its result is ready to leave.
// Reset clears all load counters, the item count and the threshold, selects
// fingerprint mode, one manager; block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module key_manager_dispatch_top #(
   parameter int MAX_MANAGERS = kmd_pkg::MAX_MANAGERS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  kmd_pkg::req_data_type         req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output kmd_pkg::rsp_data_type         rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [kmd_pkg::ADDR_W-1:0]    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int IDX_W = (MAX_MANAGERS > 1) ? $clog2(MAX_MANAGERS) : 1;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_SUM    = 8'b0000_0010,
      S_DIV    = 8'b0000_0100,
      S_SCAN   = 8'b0000_1000,
      S_DECIDE = 8'b0001_0000,
      S_PICK   = 8'b0010_0000,
      S_INC    = 8'b0100_0000,
      S_OUT    = 8'b1000_0000
   } state_type;

   state_type                    state_ff, state_in;
   logic [1:0]                   scheme_mode_ff, scheme_mode_in;
   logic [kmd_pkg::CNT_W-1:0]    manager_count_ff, manager_count_in;
   logic [31:0]                  threshold_ff, threshold_in;
   logic                         cfg_write;
   logic [1:0]                   reg_idx;

   kmd_pkg::req_data_type        item_ff, item_in;
   logic [1:0]                   word_idx_ff, word_idx_in;
   logic [kmd_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [63:0]                  cur_word;
   logic                         start_ff, start_in;
   logic [kmd_pkg::CNT_W-1:0]    n_val;

   logic [kmd_pkg::CNT_W-1:0]    scan_issue_ff, scan_issue_in;
   logic                         cmp_valid_ff, cmp_valid_in;
   logic [kmd_pkg::CNT_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic [31:0]                  lo_ff, lo_in;
   logic [31:0]                  hi_ff, hi_in;
   logic [kmd_pkg::CNT_W-1:0]    lo_idx_ff, lo_idx_in;

   logic [IDX_W-1:0]             pick_ff, pick_in;
   logic                         rebal_ff, rebal_in;
   logic [31:0]                  items_seen_ff, items_seen_in;
   logic [31:0]                  pick_ext;

   logic                         rsp_valid_ff, rsp_valid_in;
   kmd_pkg::rsp_data_type        rsp_data_ff, rsp_data_in;
   logic                         out_load;
   logic                         req_accept;

   kmd_pkg::rem_req_type         rem_req;
   kmd_pkg::rem_sts_type         rem_sts;

   logic                         mem_re;
   logic [IDX_W-1:0]             mem_raddr;
   logic [31:0]                  mem_rdata;
   logic                         mem_we;
   logic [IDX_W-1:0]             mem_waddr;
   logic [31:0]                  mem_wdata;
   logic                         scan_re;

   // Configuration registers.
   assign pready = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign reg_idx = paddr[3:2];

   always_comb begin
      scheme_mode_in = scheme_mode_ff;
      manager_count_in = manager_count_ff;
      threshold_in = threshold_ff;
      if (cfg_write) begin
         case (reg_idx)
            kmd_pkg::REG_MODE: begin
               scheme_mode_in = pwdata[1:0];
            end
            kmd_pkg::REG_COUNT: begin
               manager_count_in = pwdata[kmd_pkg::CNT_W-1:0];
            end
            kmd_pkg::REG_THRESH: begin
               threshold_in = pwdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         kmd_pkg::REG_MODE:   prdata = {30'd0, scheme_mode_ff};
         kmd_pkg::REG_COUNT:  prdata = {28'd0, manager_count_ff};
         kmd_pkg::REG_THRESH: prdata = threshold_ff;
         default:             prdata = '0;
      endcase
   end

   always_comb begin
      if (manager_count_ff == '0) begin
         n_val = 4'd1;
      end else if (32'(manager_count_ff) > MAX_MANAGERS) begin
         n_val = kmd_pkg::CNT_W'(MAX_MANAGERS);
      end else begin
         n_val = manager_count_ff;
      end
   end

   // Shared remainder unit and counter memory.
   assign rem_req.start = start_ff;
   assign rem_req.dividend = (scheme_mode_ff == kmd_pkg::MODE_RR) ? items_seen_ff
                                                                   : {3'd0, sum_ff, 16'd0};
   assign rem_req.divisor = n_val;
   assign rem_req.iters = (scheme_mode_ff == kmd_pkg::MODE_RR) ? kmd_pkg::RR_ITERS
                                                               : kmd_pkg::FP_ITERS;

   kmd_rem_unit u_rem (
      .clock   (clock),
      .reset   (reset),
      .rem_req (rem_req),
      .rem_sts (rem_sts)
   );

   assign scan_re = (state_ff == S_SCAN) && (scan_issue_ff < n_val);
   assign mem_re = scan_re || (state_ff == S_PICK);
   assign mem_raddr = (state_ff == S_PICK) ? pick_ff : IDX_W'(scan_issue_ff);
   assign mem_we = (state_ff == S_INC);
   assign mem_waddr = pick_ff;
   assign mem_wdata = mem_rdata + 32'd1;

   kmd_load_mem #(
      .DEPTH (MAX_MANAGERS),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata)
   );

   // Sequencer.
   assign req_ready = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);
   assign pick_ext = 32'(pick_ff);

   always_comb begin
      case (word_idx_ff)
         2'd0:    cur_word = item_ff.fp_word0;
         2'd1:    cur_word = item_ff.fp_word1;
         2'd2:    cur_word = item_ff.fp_word2;
         default: cur_word = item_ff.fp_word3;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      word_idx_in = word_idx_ff;
      sum_in = sum_ff;
      start_in = 1'b0;
      scan_issue_in = scan_issue_ff;
      cmp_valid_in = scan_re;
      cmp_idx_in = scan_issue_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      lo_idx_in = lo_idx_ff;
      pick_in = pick_ff;
      rebal_in = rebal_ff;
      items_seen_in = items_seen_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               item_in = req_data;
               word_idx_in = '0;
               sum_in = '0;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            sum_in = sum_ff + kmd_pkg::SUM_W'(kmd_pkg::word_byte_sum(cur_word));
            word_idx_in = word_idx_ff + 2'd1;
            if (word_idx_ff == 2'd3) begin
               start_in = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_sts.done) begin
               pick_in = IDX_W'(rem_sts.remainder);
               rebal_in = 1'b0;
               scan_issue_in = '0;
               if (scheme_mode_ff == kmd_pkg::MODE_TUNE) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_PICK;
               end
            end
         end
         S_SCAN: begin
            if (scan_re) begin
               scan_issue_in = scan_issue_ff + 4'd1;
            end
            if (cmp_valid_ff) begin
               if (cmp_idx_ff == '0) begin
                  lo_in = mem_rdata;
                  hi_in = mem_rdata;
                  lo_idx_in = '0;
               end else begin
                  if (mem_rdata < lo_ff) begin
                     lo_in = mem_rdata;
                     lo_idx_in = cmp_idx_ff;
                  end
                  if (mem_rdata > hi_ff) begin
                     hi_in = mem_rdata;
                  end
               end
               if (cmp_idx_ff == n_val - 4'd1) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            if (hi_ff - lo_ff > threshold_ff) begin
               pick_in = IDX_W'(lo_idx_ff);
               rebal_in = 1'b1;
            end
            state_in = S_PICK;
         end
         S_PICK: begin
            state_in = S_INC;
         end
         S_INC: begin
            items_seen_in = items_seen_ff + 32'd1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_load) begin
               rsp_data_in.manager_index = pick_ext[2:0];
               rsp_data_in.rebalanced = rebal_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         scheme_mode_ff <= kmd_pkg::MODE_FP;
         manager_count_ff <= 4'd1;
         threshold_ff <= '0;
         start_ff <= 1'b0;
         cmp_valid_ff <= 1'b0;
         items_seen_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         scheme_mode_ff <= scheme_mode_in;
         manager_count_ff <= manager_count_in;
         threshold_ff <= threshold_in;
         start_ff <= start_in;
         cmp_valid_ff <= cmp_valid_in;
         items_seen_ff <= items_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      word_idx_ff <= word_idx_in;
      sum_ff <= sum_in;
      scan_issue_ff <= scan_issue_in;
      cmp_idx_ff <= cmp_idx_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      lo_idx_ff <= lo_idx_in;
      pick_ff <= pick_in;
      rebal_ff <= rebal_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

`ifndef SYNTHESIS
   a_rem_done_in_div: assert property (@(posedge clock) disable iff (reset)
      rem_sts.done |-> state_ff == S_DIV)
      else $error("remainder unit finished outside the divide state");

   a_items_seen_step: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> items_seen_ff == $past(items_seen_ff) + 32'd1)
      else $error("item count did not advance with a counter update");

   a_pick_in_range: assert property (@(posedge clock) disable iff (reset)
      out_load |-> 32'(pick_ff) < 32'(n_val))
      else $error("chosen manager is outside the managers in use");

   a_rebal_tunable: assert property (@(posedge clock) disable iff (reset)
      out_load && rebal_ff |-> scheme_mode_ff == kmd_pkg::MODE_TUNE)
      else $error("rebalanced flag raised outside tunable mode");
`endif

endmodule

FILE: verif/kmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmd_checker
// Watches the register port and both channels of the key manager dispatcher.
// It keeps its own copy of the registers, the per-manager load counters and
// the item count, predicts the manager pick for every request transfer, and
// compares each response transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module kmd_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  kmd_pkg::req_data_type      req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  kmd_pkg::rsp_data_type      rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic                       pready,
   input  logic [kmd_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                pwdata,
   output int                         mismatch_count,
   output int                         pending_count
);

   localparam int MGR_MAX = kmd_pkg::MAX_MANAGERS_DEF;

   logic [1:0]            scheme_mode;
   logic [3:0]            manager_count;
   logic [31:0]           deviation_limit;
   logic [31:0]           manager_load [MGR_MAX];
   logic [31:0]           chunks_dispatched;
   kmd_pkg::rsp_data_type expected_picks [$];

   function automatic int fp_byte_total(input kmd_pkg::req_data_type fp);
      int total;
      total = 0;
      for (int i = 0; i < 32; i++) begin
         total += int'(fp[8*i +: 8]);
      end
      return total;
   endfunction

   task automatic dispatch_chunk(input kmd_pkg::req_data_type fp,
                                 output kmd_pkg::rsp_data_type pick);
      int          active;
      int          chosen;
      int          least_idx;
      logic [31:0] least;
      logic [31:0] most;
      logic        shifted;
      shifted = 1'b0;
      if (manager_count == 4'd0) begin
         active = 1;
      end else if (int'(manager_count) > MGR_MAX) begin
         active = MGR_MAX;
      end else begin
         active = int'(manager_count);
      end
      case (scheme_mode)
         kmd_pkg::MODE_RR: begin
            chosen = int'(chunks_dispatched % 32'(active));
         end
         kmd_pkg::MODE_TUNE: begin
            least = manager_load[0];
            most = manager_load[0];
            least_idx = 0;
            for (int i = 1; i < active; i++) begin
               if (manager_load[i] < least) begin
                  least = manager_load[i];
                  least_idx = i;
               end
               if (manager_load[i] > most) begin
                  most = manager_load[i];
               end
            end
            if (most - least <= deviation_limit) begin
               chosen = fp_byte_total(fp) % active;
            end else begin
               chosen = least_idx;
               shifted = 1'b1;
            end
         end
         default: begin
            chosen = fp_byte_total(fp) % active;
         end
      endcase
      manager_load[chosen] += 32'd1;
      chunks_dispatched += 32'd1;
      pick.manager_index = 3'(chosen);
      pick.rebalanced = shifted;
   endtask

   always @(posedge clock) begin
      kmd_pkg::rsp_data_type predicted;
      kmd_pkg::rsp_data_type oldest;
      if (reset) begin
         scheme_mode = kmd_pkg::MODE_FP;
         manager_count = 4'd1;
         deviation_limit = '0;
         for (int i = 0; i < MGR_MAX; i++) begin
            manager_load[i] = '0;
         end
         chunks_dispatched = '0;
         expected_picks.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[kmd_pkg::ADDR_W-1:2])
               kmd_pkg::REG_MODE:   scheme_mode = pwdata[1:0];
               kmd_pkg::REG_COUNT:  manager_count = pwdata[3:0];
               kmd_pkg::REG_THRESH: deviation_limit = pwdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_picks.size() == 0) begin
               mismatch_count++;
               $display("%0t: stray response, expected none, actual %0d/%0b",
                        $time, rsp_data.manager_index, rsp_data.rebalanced);
            end else begin
               oldest = expected_picks.pop_front();
               if (rsp_data.manager_index !== oldest.manager_index) begin
                  mismatch_count++;
                  $display("%0t: manager_index mismatch, expected %0d, actual %0d",
                           $time, oldest.manager_index, rsp_data.manager_index);
               end
               if (rsp_data.rebalanced !== oldest.rebalanced) begin
                  mismatch_count++;
                  $display("%0t: rebalanced mismatch, expected %0b, actual %0b",
                           $time, oldest.rebalanced, rsp_data.rebalanced);
               end
            end
         end
         if (req_valid && req_ready) begin
            dispatch_chunk(req_data, predicted);
            expected_picks = {expected_picks, predicted};
         end
      end
      pending_count = expected_picks.size();
   end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the key manager dispatcher.
// Drives fingerprints and register writes, with random gaps on both channels,
// one long response stall and drained pauses at every settings change. A
// directed part covers byte sum extremes, all modes and the saturating and
// unmapped register cases; random phases with random settings follow. The
// checker instance predicts and compares every response transfer.
// ----------------------------------------------------------------------------
module tb;

   localparam int         STALL_LIMIT  = 4000;
   localparam int         TARGET_ITEMS = 2000;
   localparam int         DRAIN_CYCLES = 40;
   localparam logic [1:0] MODE_SPARE   = 2'd3;
   localparam logic [1:0] REG_UNMAPPED = 2'd3;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   kmd_pkg::req_data_type       req_data = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   kmd_pkg::rsp_data_type       rsp_data;
   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [kmd_pkg::ADDR_W-1:0]  paddr = '0;
   logic [31:0]                 pwdata = '0;
   logic [31:0]                 prdata;
   logic                        pready;
   int                          mismatches;
   int                          pending;
   int                          chunks_sent = 0;
   int                          rsp_hold_len = 0;
   bit                          steady = 1'b0;

   always #1 clock = ~clock;

   key_manager_dispatch_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   kmd_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatch_count (mismatches),
      .pending_count  (pending)
   );

   function automatic int idle_gap();
      return steady ? 0 : $urandom_range(0, 8);
   endfunction

   function automatic kmd_pkg::req_data_type fp_fill(input logic [7:0] value);
      kmd_pkg::req_data_type fp;
      fp = {32{value}};
      return fp;
   endfunction

   function automatic kmd_pkg::req_data_type random_fingerprint();
      kmd_pkg::req_data_type fp;
      case ($urandom_range(0, 9))
         0: fp = '0;
         1: fp = '1;
         2: begin
            fp = '0;
            fp[8*$urandom_range(0, 31) +: 8] = 8'($urandom);
         end
         3: fp = fp_fill(8'($urandom));
         default: begin
            fp = {$urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom};
         end
      endcase
      return fp;
   endfunction

   function automatic logic [31:0] random_threshold();
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return 32'($urandom_range(1, 8));
         2: return 32'($urandom_range(9, 200));
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer
   // with valid still high, so a back-to-back item needs no second update.
   task automatic send_chunk(input kmd_pkg::req_data_type fp);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= fp;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      chunks_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (pending == 0);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // Upper bits are filled with noise; the block keeps only the field width.
   task automatic load_settings(input logic [1:0] mode, input logic [3:0] count,
                                input logic [31:0] limit);
      drain();
      csr_write(kmd_pkg::REG_MODE, {30'($urandom), mode});
      csr_write(kmd_pkg::REG_COUNT, {28'($urandom), count});
      csr_write(kmd_pkg::REG_THRESH, limit);
   endtask

   initial begin
      int gap;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (rsp_hold_len > 0) begin
            gap = rsp_hold_len;
            rsp_hold_len = 0;
         end else begin
            gap = idle_gap();
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      kmd_pkg::req_data_type fp;
      int phase;
      int phase_items;
      logic [3:0] count;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_chunk('0);
      send_chunk(fp_fill(8'hFF));

      load_settings(kmd_pkg::MODE_FP, 4'd8, 32'd0);
      send_chunk('0);
      send_chunk(fp_fill(8'hFF));
      fp = '0;
      fp.fp_word0 = 64'd1;
      send_chunk(fp);
      fp = '0;
      fp.fp_word3 = 64'h8000_0000_0000_0000;
      send_chunk(fp);

      load_settings(kmd_pkg::MODE_RR, 4'd3, 32'd0);
      repeat (4) send_chunk(random_fingerprint());

      load_settings(kmd_pkg::MODE_TUNE, 4'd4, 32'd0);
      repeat (4) send_chunk(fp_fill(8'hFF));

      load_settings(kmd_pkg::MODE_TUNE, 4'd8, 32'hFFFF_FFFF);
      repeat (2) send_chunk(random_fingerprint());

      load_settings(MODE_SPARE, 4'd0, 32'd1);
      repeat (2) send_chunk(fp_fill(8'h5A));

      load_settings(kmd_pkg::MODE_RR, 4'd15, 32'd5);
      repeat (3) send_chunk(random_fingerprint());

      drain();
      csr_write(REG_UNMAPPED, 32'hFFFF_FFFF);
      repeat (2) send_chunk(random_fingerprint());

      load_settings(kmd_pkg::MODE_TUNE, 4'd2, 32'd1);
      repeat (3) send_chunk(random_fingerprint());

      phase = 0;
      while (chunks_sent < TARGET_ITEMS) begin
         count = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 8));
         load_settings(2'($urandom_range(0, 3)), count, random_threshold());
         steady = ($urandom_range(0, 3) == 0);
         if (phase == 3) begin
            steady = 1'b1;
            rsp_hold_len = 300;
         end
         phase_items = $urandom_range(20, 120);
         repeat (phase_items) send_chunk(random_fingerprint());
         phase++;
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
